FILE: src/oat_pkg.sv
// Shared types and constants for the outstanding ack tracker.
package oat_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int LANES       = 8;
	localparam int ROWS        = (TABLE_DEPTH + LANES - 1) / LANES;
	localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int LANE_W      = $clog2(LANES);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int NODE_W  = 7;
	localparam int NUM_W   = 32;
	localparam int ENTRY_W = NODE_W + NUM_W;
	localparam int LIMIT_W = 7;
	localparam int PEND_W  = 7;
	localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	localparam logic [PEND_W-1:0]  PEND_MAX       = '1;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 7'd64;

	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 5;
	localparam int OUT_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_LIMIT   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NEGATIVE_LIMIT = 1'b1;

	localparam logic CMD_SEND = 1'b0;
	localparam logic CMD_ACK  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load_req;
		logic scan_start;
		logic scan_run;
		logic finish;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_scan;
		logic scan_done;
		logic out_free;
	} ctrl_stat_t;

	// Packed with granted in the lowest bit.
	typedef struct packed {
		logic [PEND_W-1:0] pending_count;
		status_t           status;
		logic              ack_matched;
		logic              logged;
		logic              granted;
	} result_t;

endpackage

FILE: src/oat_ram.sv
// Generic single-write, single-read RAM with registered read data.
module oat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/oat_ctrl.sv
// Sequencer for accept, decision, table scan and result handoff.
module oat_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  oat_pkg::ctrl_stat_t sts,
	output oat_pkg::ctrl_cmd_t  ctl
);

	import oat_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt     = state_q;
		ctl           = '0;
		s_axis_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					ctl.load_req = 1'b1;
					state_nxt    = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.need_scan) begin
					ctl.scan_start = 1'b1;
					state_nxt      = S_SCAN;
				end else begin
					ctl.finish = 1'b1;
					state_nxt  = S_RESP;
				end
			end
			S_SCAN: begin
				ctl.scan_run = 1'b1;
				if (sts.scan_done) begin
					ctl.finish = 1'b1;
					state_nxt  = S_RESP;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					ctl.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

FILE: src/oat_dp.sv
// Datapath: request registers, credit gating, banked entry table and output register.
module oat_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  oat_pkg::ctrl_cmd_t                ctl,
	output oat_pkg::ctrl_stat_t               sts,
	input  logic [oat_pkg::IN_DATA_W-1:0]     in_data,
	input  logic [oat_pkg::IN_USER_W-1:0]     in_user,
	input  logic                              cfg_we,
	input  logic [oat_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [oat_pkg::LIMIT_W-1:0]       cfg_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [oat_pkg::OUT_DATA_W-1:0]    out_data
);

	import oat_pkg::*;

	logic               req_cmd_q;
	logic [NODE_W-1:0]  req_node_q;
	logic [NUM_W-1:0]   req_num_q;
	logic               req_sys_q;
	logic               req_anti_q;
	logic               req_mov_q;
	logic               req_hdl_q;

	logic [LIMIT_W-1:0] normal_limit_q;
	logic [LIMIT_W-1:0] negative_limit_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_nxt;
	logic               busy_q [ROWS][LANES];

	logic [ROW_W-1:0]   row_q;
	logic               iss_q;
	logic               chk_s1;
	logic [ROW_W-1:0]   chk_row_s1;

	logic [ENTRY_W-1:0] rd_data [LANES];
	logic [LANES-1:0]   ram_we;
	logic               hit_any;
	logic [LANE_W-1:0]  hit_lane;
	logic               commit;

	logic               go;
	logic               need_log;
	logic [CMP_W-1:0]   cnt_x;
	logic [CMP_W-1:0]   cnt_nxt_x;

	result_t            res_q;
	result_t            out_q;
	logic               out_valid_q;

	always_ff @(posedge clk) begin
		if (ctl.load_req) begin
			req_node_q <= in_data[NODE_W-1:0];
			req_num_q  <= in_data[NODE_W +: NUM_W];
			req_cmd_q  <= in_user[0];
			req_sys_q  <= in_user[1];
			req_anti_q <= in_user[2];
			req_mov_q  <= in_user[3];
			req_hdl_q  <= in_user[4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_limit_q   <= LIMIT_RESET;
			negative_limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NORMAL_LIMIT:   normal_limit_q   <= cfg_data;
				REG_NEGATIVE_LIMIT: negative_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cnt_x    = CMP_W'(cnt_q);
	assign go       = req_sys_q
	               || (req_anti_q && (cnt_x < CMP_W'(negative_limit_q)))
	               || (cnt_x < CMP_W'(normal_limit_q));
	assign need_log = go && !req_sys_q && !req_mov_q && !req_hdl_q;

	assign sts.need_scan = (req_cmd_q == CMD_ACK) || need_log;

	// Row scan: issue one row address per cycle, compare that row in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			iss_q      <= 1'b0;
			chk_s1     <= 1'b0;
			chk_row_s1 <= '0;
		end else if (ctl.scan_start) begin
			row_q  <= '0;
			iss_q  <= 1'b1;
			chk_s1 <= 1'b0;
		end else if (ctl.scan_run) begin
			chk_s1     <= iss_q;
			chk_row_s1 <= row_q;
			if (iss_q) begin
				if (row_q == ROW_W'(ROWS - 1)) begin
					iss_q <= 1'b0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		logic cand;
		hit_any  = 1'b0;
		hit_lane = '0;
		for (int l = LANES - 1; l >= 0; l--) begin
			if ((int'(chk_row_s1) * LANES + l) < TABLE_DEPTH) begin
				if (req_cmd_q == CMD_SEND) begin
					cand = !busy_q[chk_row_s1][l];
				end else begin
					cand = busy_q[chk_row_s1][l]
					    && (rd_data[l][ENTRY_W-1 -: NODE_W] == req_node_q)
					    && (rd_data[l][NUM_W-1:0] == req_num_q);
				end
			end else begin
				cand = 1'b0;
			end
			if (cand) begin
				hit_any  = 1'b1;
				hit_lane = LANE_W'(l);
			end
		end
	end

	assign sts.scan_done = chk_s1 && (hit_any || (chk_row_s1 == ROW_W'(ROWS - 1)));
	assign commit        = ctl.finish && ctl.scan_run && chk_s1 && hit_any;

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		assign ram_we[g] = commit && (req_cmd_q == CMD_SEND) && (hit_lane == LANE_W'(g));

		oat_ram #(
			.WIDTH (ENTRY_W),
			.DEPTH (ROWS)
		) u_ram (
			.clk   (clk),
			.we    (ram_we[g]),
			.waddr (chk_row_s1),
			.wdata ({req_node_q, req_num_q}),
			.raddr (row_q),
			.rdata (rd_data[g])
		);
	end

	always_comb begin
		cnt_nxt = cnt_q;
		if (commit) begin
			if (req_cmd_q == CMD_SEND) begin
				cnt_nxt = cnt_q + 1'b1;
			end else if (cnt_q != '0) begin
				cnt_nxt = cnt_q - 1'b1;
			end
		end
	end

	assign cnt_nxt_x = CMP_W'(cnt_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= '{default: '{default: 1'b0}};
		end else if (commit) begin
			cnt_q                       <= cnt_nxt;
			busy_q[chk_row_s1][hit_lane] <= (req_cmd_q == CMD_SEND);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			res_q.granted       <= (req_cmd_q == CMD_SEND) && go;
			res_q.logged        <= (req_cmd_q == CMD_SEND) && commit;
			res_q.ack_matched   <= (req_cmd_q == CMD_ACK) && commit;
			if (req_cmd_q == CMD_ACK) begin
				res_q.status <= commit ? ST_OK : ST_NOT_FOUND;
			end else begin
				res_q.status <= (need_log && !commit) ? ST_FULL : ST_OK;
			end
			res_q.pending_count <= (cnt_nxt_x > CMP_W'(PEND_MAX)) ? PEND_MAX
			                                                      : cnt_nxt_x[PEND_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_q <= res_q;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = OUT_DATA_W'(out_q);

endmodule

FILE: src/outstanding_ack_tracker_core.sv
// Outstanding ack table with credit-gated sends: top level.
// A send that needs no entry skips the table scan; a logged send or an ack scans
// the table one row of 8 banked entries per cycle, until a hit or the last row.
// Items are handled one at a time; the next item is taken while a result waits in the output register.
// Reset: arst_n clears the busy bits, pending count and handshakes at once; limits go to 64.
module outstanding_ack_tracker_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [oat_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // peer_node, msg_number, pad
	input  logic [oat_pkg::IN_USER_W-1:0]     s_axis_tuser,  // cmd, is_system, is_anti,
	                                                         // is_moving, to_handler
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [oat_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // granted, logged, ack_matched,
	                                                         // status, pending_count, pad
	input  logic                              cfg_we,
	input  logic [oat_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [oat_pkg::LIMIT_W-1:0]       cfg_data
);

	import oat_pkg::*;

	ctrl_cmd_t  ctl;
	ctrl_stat_t sts;

	oat_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.ctl           (ctl)
	);

	oat_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
